FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; each use expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SXF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SXF_ASSERT_NEVER(lbl, cond, msg) \
  `SXF_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/core/sxf_pkg.sv
// types, constants and the coordinate wrap table function for the sprite xor framebuffer
// no dependencies
package sxf_pkg;

  localparam int unsigned ScreenWidthDef   = 64;
  localparam int unsigned ScreenHeightDef  = 32;
  localparam int unsigned MaxSpriteRowsDef = 15;
  localparam int unsigned RowBits          = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] sprite_byte;
    logic       last_byte;
  } sxf_in_t;

  typedef struct packed {
    logic               collision;
    logic               sprite_done;
    logic [RowBits-1:0] row_pixels;
  } sxf_out_t;

  // remainder of every 8-bit coordinate by a fixed modulus
  typedef logic [255:0][7:0] wrap_tab_t;

  function automatic wrap_tab_t build_wrap_table(int unsigned modulus);
    wrap_tab_t  tab;
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = r;
      if (32'(r) + 32'd1 == modulus) begin
        r = '0;
      end else begin
        r = r + 8'd1;
      end
    end
    return tab;
  endfunction

endpackage

FILE: rtl/core/sxf_draw.sv
// one row of sprite drawing: place the byte, clip it, xor it and flag a hit
// depends on sxf_pkg
module sxf_draw
  import sxf_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = ScreenWidthDef
) (
  input  logic [RowBits-1:0]              row_i,
  input  logic [7:0]                      sprite_byte_i,
  input  logic [$clog2(SCREEN_WIDTH)-1:0] x0_i,
  output logic [RowBits-1:0]              row_o,
  output logic                            hit_o
);

  // visible columns sit at the top of the row word
  localparam logic [RowBits-1:0] VisMask =
    (SCREEN_WIDTH >= RowBits) ? {RowBits{1'b1}} : ~({RowBits{1'b1}} >> SCREEN_WIDTH);

  logic [RowBits-1:0] spr;

  always_comb begin
    spr   = ({sprite_byte_i, {(RowBits-8){1'b0}}} >> x0_i) & VisMask;
    hit_o = |(row_i & spr);
    row_o = row_i ^ spr;
  end

endmodule

FILE: rtl/core/sprite_xor_framebuffer_core.sv
// sprite xor framebuffer, top level: input register, row update, result register
// depends on sxf_pkg, sxf_draw and assert_macros.svh
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) takes one command beat:
//   clear the whole screen, draw one sprite byte, or read one row.
//   out channel (out_valid_o / out_ready_i / out_data_o) gives exactly one
//   result beat per command, in order: the collision flag of the sprite in
//   progress, sprite_done on a draw beat marked last, and the row for a read.
//   a beat passes the input register, then the result register; one beat is
//   taken every cycle while the receiver takes results, since each command
//   does one row read-modify-write (or a full clear) on the flop framebuffer.
//   the framebuffer row index comes from a constant wrap table on pos_y, plus
//   the row offset within the sprite for a draw; pos_x wraps through a second table.
//   reset blanks the screen and clears the sprite offset and collision flag;
//   in_ready_o is high as soon as reset ends.
//   when the receiver stalls, the result holds and the input register holds
//   one more beat; in_ready_o then drops until the result is taken.
`include "assert_macros.svh"

module sprite_xor_framebuffer_core
  import sxf_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH    = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT   = ScreenHeightDef,
  parameter int unsigned MAX_SPRITE_ROWS = MaxSpriteRowsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sxf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sxf_out_t out_data_o
);

  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned OW = $clog2(MAX_SPRITE_ROWS + 1);
  localparam int unsigned RW = ((YW > OW) ? YW : OW) + 1;

  localparam wrap_tab_t     XTab    = build_wrap_table(SCREEN_WIDTH);
  localparam wrap_tab_t     YTab    = build_wrap_table(SCREEN_HEIGHT);
  localparam logic [OW-1:0] MaxOfs  = OW'(MAX_SPRITE_ROWS);
  localparam logic [RW-1:0] HeightR = RW'(SCREEN_HEIGHT);

  logic               in_valid_q;
  sxf_in_t            in_q;
  logic               out_valid_q;
  sxf_out_t           out_q, out_d;
  logic [OW-1:0]      ofs_q, ofs_d;
  logic               coll_q, coll_d;
  logic [RowBits-1:0] fb_q [SCREEN_HEIGHT];

  logic               adv, fire;
  logic [XW-1:0]      x0;
  logic [YW-1:0]      y0;
  logic [RW-1:0]      row_sum;
  logic               in_range;
  logic [YW-1:0]      rd_idx;
  logic [RowBits-1:0] row_cur, row_new;
  logic               hit;
  logic               fb_we, fb_clr;
  logic               close_fire, clear_fire;

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  assign x0       = XW'(XTab[in_q.pos_x]);
  assign y0       = YW'(YTab[in_q.pos_y]);
  assign row_sum  = RW'(y0) + RW'(ofs_q);
  assign in_range = row_sum < HeightR;
  // draw and read never share a beat, so one read port serves both
  assign rd_idx   = (in_q.cmd == CMD_DRAW) ? row_sum[YW-1:0] : y0;
  assign row_cur  = fb_q[rd_idx];

  sxf_draw #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_draw (
    .row_i         (row_cur),
    .sprite_byte_i (in_q.sprite_byte),
    .x0_i          (x0),
    .row_o         (row_new),
    .hit_o         (hit)
  );

  always_comb begin
    ofs_d                = ofs_q;
    coll_d               = coll_q;
    fb_we                = 1'b0;
    fb_clr               = 1'b0;
    out_d.collision      = coll_q;
    out_d.sprite_done    = 1'b0;
    out_d.row_pixels     = '0;
    case (in_q.cmd)
      CMD_CLEAR: begin
        fb_clr = 1'b1;
      end
      CMD_DRAW: begin
        if (ofs_q < MaxOfs) begin
          ofs_d = ofs_q + OW'(1);
          if (in_range) begin
            fb_we = 1'b1;
            if (hit) begin
              coll_d = 1'b1;
            end
          end
        end
        out_d.collision   = coll_d;
        out_d.sprite_done = in_q.last_byte;
        // sprite closes after its flag has been reported
        if (in_q.last_byte) begin
          ofs_d  = '0;
          coll_d = 1'b0;
        end
      end
      CMD_READ: begin
        out_d.row_pixels = row_cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q  <= '0;
      coll_q <= 1'b0;
    end else if (fire) begin
      ofs_q  <= ofs_d;
      coll_q <= coll_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SCREEN_HEIGHT; r++) begin
        fb_q[r] <= '0;
      end
    end else if (fire) begin
      for (int r = 0; r < SCREEN_HEIGHT; r++) begin
        if (fb_clr) begin
          fb_q[r] <= '0;
        end else if (fb_we && (rd_idx == YW'(r))) begin
          fb_q[r] <= row_new;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign close_fire = fire && (in_q.cmd == CMD_DRAW) && in_q.last_byte;
  assign clear_fire = fire && (in_q.cmd == CMD_CLEAR);

  `SXF_ASSERT_NEVER(a_ofs_bound, ofs_q > MaxOfs, "sprite row offset beyond limit")
  `SXF_ASSERT(a_sprite_close, close_fire |=> (ofs_q == '0) && !coll_q, "sprite not closed")
  `SXF_ASSERT(a_clear_blank, clear_fire |=> (fb_q[0] == '0), "row 0 not blank after clear")

endmodule
